// ===== src/battery_charge_smoother_macros.svh =====
// Assertion macros for the battery charge smoother.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef BATTERY_CHARGE_SMOOTHER_MACROS_SVH
`define BATTERY_CHARGE_SMOOTHER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define BCS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== src/bcs_pkg.sv =====
// Shared constants for the battery charge smoother.
// Used by bcs_ram, bcs_div and the top level; no dependencies.
package bcs_pkg;

  localparam int unsigned CHARGE_W   = 7;
  localparam int unsigned QUO_W      = 7;
  localparam int unsigned WINDOW_DEF = 8;

  localparam logic [CHARGE_W-1:0] CHARGE_MAX    = 7'd100;
  localparam logic [CHARGE_W-1:0] MAX_STEP_RST  = 7'd5;

  // Width of a sum of up to win full-scale readings.
  function automatic int unsigned sum_width(input int unsigned win);
    return $clog2(win * 100 + 1);
  endfunction

endpackage

// ===== src/bcs_ram.sv =====
// Window storage for the battery charge smoother: one write and one read port,
// read data registered. Depends on bcs_pkg.
module bcs_ram
  import bcs_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(WINDOW)-1:0]  wr_addr,
  input  logic [CHARGE_W-1:0]        wr_data,
  input  logic [$clog2(WINDOW)-1:0]  rd_addr,
  output logic [CHARGE_W-1:0]        rd_data
);

  logic [CHARGE_W-1:0] mem_r [WINDOW];
  logic [CHARGE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/bcs_div.sv =====
// Window average: divides the window sum by the constant window length with a
// reciprocal multiply, quotient registered on start. Depends on bcs_pkg.
module bcs_div
  import bcs_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [sum_width(WINDOW)-1:0]      sum,
  output logic                              done,
  output logic [QUO_W-1:0]                  quotient
);

  localparam int unsigned SUM_W  = sum_width(WINDOW);
  localparam int unsigned LW     = $clog2(WINDOW);
  localparam int unsigned SH     = SUM_W + LW;
  localparam int unsigned MW     = SUM_W + 2;
  localparam int unsigned PROD_W = SUM_W + MW;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_VAL);

  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo_r;
  logic              done_r;

  // The reciprocal is rounded up with SUM_W + log2(WINDOW) fraction bits, which
  // keeps the truncated quotient exact for every sum that fits in SUM_W bits.
  assign prod = PROD_W'(sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= prod[SH +: QUO_W];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/battery_charge_smoother.sv =====
// Battery charge smoother, top level.
// Depends on bcs_pkg, bcs_ram, bcs_div and battery_charge_smoother_macros.svh.
//
// Input words carry one charge reading (in_charge_percent); readings above 100
// are clamped to 100. Each input word produces exactly one output word with the
// charge to display and the fluctuating flag. Both channels use valid/stall.
// The max_step register is written through cfg_wr_en/cfg_wr_data; the user
// must do so only while idle, which the block itself does not enforce.
//
// The last WINDOW readings sit in a circular buffer in a synchronous RAM. Until
// the window is full, an accepted word goes from S_IDLE straight to S_FIN. Once
// it is full, every word walks the buffer oldest to newest, one RAM read per
// cycle, and then, unless a large step ends the walk early, forms the average
// with a registered reciprocal multiply. One word is in work at a time; the
// next word is taken as soon as the previous result sits in the output
// register, even while it is stalled.
//
// Reset empties the window, clears the flag and the average and sets max_step
// to 5. No RAM clearing is needed because unwritten entries are never read.
// A stalled output word holds its value until taken.
module battery_charge_smoother
  import bcs_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CHARGE_W-1:0] in_charge_percent,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHARGE_W-1:0] out_shown_charge,
  output logic                out_fluctuating,
  input  logic                cfg_wr_en,
  input  logic [CHARGE_W-1:0] cfg_wr_data
);

  `include "battery_charge_smoother_macros.svh"

  localparam int unsigned AW    = $clog2(WINDOW);
  localparam int unsigned CW    = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = sum_width(WINDOW);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DIV, S_FIN} state_t;
  typedef enum logic [1:0] {DIR_NONE, DIR_UP, DIR_DOWN} dir_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [AW-1:0]       fill_r, fill_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CHARGE_W-1:0] pct_r, pct_nxt;
  logic [CHARGE_W-1:0] prev_r, prev_nxt;
  logic [CHARGE_W-1:0] avg_r, avg_nxt;
  logic [CHARGE_W-1:0] max_step_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  dir_t                dir_r, dir_nxt;
  logic [1:0]          rev_r, rev_nxt;
  logic                flag_r, flag_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHARGE_W-1:0] out_charge_r, out_charge_nxt;
  logic                out_fluct_r, out_fluct_nxt;

  logic                in_acc;
  logic [CHARGE_W-1:0] in_sat;
  logic [CHARGE_W-1:0] rd_data;
  logic [SUM_W-1:0]    sum_add;
  logic [CHARGE_W-1:0] mag;
  logic                step_up;
  logic                step_down;
  logic                div_start;
  logic                div_done;
  logic [QUO_W-1:0]    div_q;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == AW'(WINDOW - 1)) ? '0 : a + 1'b1;
  endfunction

  assign in_acc  = in_valid && (state_r == S_IDLE);
  assign in_sat  = (in_charge_percent > CHARGE_MAX) ? CHARGE_MAX : in_charge_percent;
  assign sum_add = sum_r + SUM_W'(rd_data);

  assign step_up   = rd_data > prev_r;
  assign step_down = rd_data < prev_r;
  assign mag       = step_up ? (rd_data - prev_r) : (prev_r - rd_data);

  // Writes happen only on accept and read data is used only during the walk, so
  // no read that meets a write to the same entry is ever used.
  bcs_ram #(.WINDOW(WINDOW)) u_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wp_r),
    .wr_data (in_sat),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  bcs_div #(.WINDOW(WINDOW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum      (sum_add),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    rd_addr_nxt    = rd_addr_r;
    cnt_nxt        = cnt_r;
    pct_nxt        = pct_r;
    prev_nxt       = prev_r;
    avg_nxt        = avg_r;
    sum_nxt        = sum_r;
    dir_nxt        = dir_r;
    rev_nxt        = rev_r;
    flag_nxt       = flag_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_charge_nxt = out_charge_r;
    out_fluct_nxt  = out_fluct_r;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pct_nxt = in_sat;
          wp_nxt  = addr_inc(wp_r);
          if (fill_r == AW'(WINDOW - 1)) begin
            // Window full with this word: oldest entry sits just past the new one.
            rd_addr_nxt = addr_inc(wp_r);
            cnt_nxt     = '0;
            sum_nxt     = '0;
            dir_nxt     = DIR_NONE;
            rev_nxt     = 2'd0;
            state_nxt   = S_WALK;
          end else begin
            fill_nxt  = fill_r + 1'b1;
            state_nxt = S_FIN;
          end
        end
      end

      S_WALK: begin
        if (cnt_r < CW'(WINDOW)) begin
          rd_addr_nxt = addr_inc(rd_addr_r);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(1)) begin
          prev_nxt = rd_data;
          sum_nxt  = SUM_W'(rd_data);
        end else if (cnt_r != '0) begin
          if (mag >= max_step_r) begin
            flag_nxt  = 1'b0;
            state_nxt = S_FIN;
          end else begin
            prev_nxt = rd_data;
            sum_nxt  = sum_add;
            if (step_up) begin
              dir_nxt = DIR_UP;
            end else if (step_down) begin
              dir_nxt = DIR_DOWN;
            end
            if (dir_r != DIR_NONE && dir_nxt != dir_r && rev_r != 2'd2) begin
              rev_nxt = rev_r + 1'b1;
            end
            if (cnt_r == CW'(WINDOW)) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          avg_nxt   = div_q;
          flag_nxt  = (rev_r == 2'd2);
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_charge_nxt = flag_r ? avg_r : pct_r;
          out_fluct_nxt  = flag_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      rd_addr_r   <= '0;
      cnt_r       <= '0;
      avg_r       <= '0;
      flag_r      <= 1'b0;
      dir_r       <= DIR_NONE;
      rev_r       <= 2'd0;
      out_valid_r <= 1'b0;
      max_step_r  <= MAX_STEP_RST;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      rd_addr_r   <= rd_addr_nxt;
      cnt_r       <= cnt_nxt;
      avg_r       <= avg_nxt;
      flag_r      <= flag_nxt;
      dir_r       <= dir_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_step_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pct_r        <= pct_nxt;
    prev_r       <= prev_nxt;
    sum_r        <= sum_nxt;
    out_charge_r <= out_charge_nxt;
    out_fluct_r  <= out_fluct_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_shown_charge = out_charge_r;
  assign out_fluctuating  = out_fluct_r;

  `BCS_ASSERT_ALWAYS(a_fill_range, fill_r <= AW'(WINDOW - 1), "fill count beyond window")
  `BCS_ASSERT_ALWAYS(a_div_in_state, !div_done || state_r == S_DIV,
                     "divider finished outside the divide phase")
  `BCS_ASSERT_ALWAYS(a_out_range, !out_valid_r || out_charge_r <= CHARGE_MAX,
                     "shown charge above full scale")
  `BCS_ASSERT_NEXT(a_walk_on_full, state_r == S_IDLE && in_valid && fill_r != AW'(WINDOW - 1),
                   state_r == S_FIN, "walk started before the window was full")

endmodule

// ===== tb/bcs_checker.sv =====
// Scoreboard for the battery charge smoother: watches both channels and the
// max_step write port, predicts each output word and compares it field by field.
// Depends on bcs_pkg for the charge width, the clamp level and the reset step.
module bcs_checker
  import bcs_pkg::*;
#(
  parameter int unsigned WIN = WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [CHARGE_W-1:0] in_charge_percent,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [CHARGE_W-1:0] out_shown_charge,
  input  logic                out_fluctuating,
  input  logic                cfg_wr_en,
  input  logic [CHARGE_W-1:0] cfg_wr_data,
  output int unsigned         mismatches,
  output int unsigned         displays_owed,
  output int unsigned         smoothed_shown
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHARGE_W-1:0] shown;
    logic                fluct;
  } display_t;

  display_t            pending_displays[$];
  logic [CHARGE_W-1:0] history[WIN];
  int unsigned         fill;
  logic [CHARGE_W-1:0] step_limit;
  logic [CHARGE_W-1:0] stored_avg;
  logic                fluct_state;
  int unsigned         words_seen;

  initial begin
    mismatches     = 0;
    displays_owed  = 0;
    smoothed_shown = 0;
    words_seen     = 0;
  end

  task automatic log_error(input string what);
    mismatches++;
    $display("[%0t] mismatch on output word %0d: %s", $realtime, words_seen, what);
  endtask

  // Appends one clamped reading and, once the window is full, walks it to update
  // the fluctuation flag and, if no large step ends the walk, the stored average.
  function automatic display_t smooth_reading(input logic [CHARGE_W-1:0] raw);
    logic [CHARGE_W-1:0] level;
    int                  heading;
    int                  last_heading;
    int                  delta;
    int                  turns;
    int                  total;
    int                  i;
    bit                  jumped;
    display_t            d;
    level = (raw > CHARGE_MAX) ? CHARGE_MAX : raw;
    if (fill < WIN) begin
      history[fill] = level;
      fill++;
    end
    if (fill >= WIN) begin
      heading = 0;
      turns   = 0;
      total   = 0;
      jumped  = 1'b0;
      for (i = 0; i < WIN - 1 && !jumped; i++) begin
        last_heading = heading;
        delta = int'(history[i + 1]) - int'(history[i]);
        total += int'(history[i]);
        if ((delta < 0 ? -delta : delta) >= int'(step_limit)) begin
          jumped = 1'b1;
        end else begin
          // A flat step keeps the direction of the last real move.
          if (delta > 0) heading = 1;
          else if (delta < 0) heading = -1;
          if (last_heading != 0 && heading != last_heading) turns++;
        end
      end
      if (jumped) begin
        fluct_state = 1'b0;
      end else begin
        total += int'(history[WIN - 1]);
        stored_avg  = CHARGE_W'(total / WIN);
        fluct_state = (turns > 1);
      end
      for (i = 0; i < WIN - 1; i++) history[i] = history[i + 1];
      fill = WIN - 1;
    end
    d.shown = fluct_state ? stored_avg : level;
    d.fluct = fluct_state;
    return d;
  endfunction

  always @(posedge clk) begin
    display_t want;
    if (!rst_n) begin
      step_limit  = MAX_STEP_RST;
      fill        = 0;
      stored_avg  = '0;
      fluct_state = 1'b0;
      pending_displays.delete();
    end else begin
      if (cfg_wr_en) step_limit = cfg_wr_data;
      // Retire the output first; a word cannot leave on the edge it enters.
      if (out_valid && !out_stall) begin
        words_seen++;
        if (pending_displays.size() == 0) begin
          log_error("output word with nothing expected");
        end else begin
          want = pending_displays.pop_front();
          if (out_shown_charge !== want.shown) begin
            log_error($sformatf("shown_charge %0d, expected %0d",
                                out_shown_charge, want.shown));
          end
          if (out_fluctuating !== want.fluct) begin
            log_error($sformatf("fluctuating %0b, expected %0b",
                                out_fluctuating, want.fluct));
          end
          if (want.fluct) smoothed_shown++;
        end
      end
      if (in_valid && !in_stall) begin
        pending_displays.push_back(smooth_reading(in_charge_percent));
      end
    end
    displays_owed <= pending_displays.size();
  end

endmodule

// ===== tb/tb_battery_charge_smoother.sv =====
// Testbench top for the battery charge smoother: clock, reset, readings and
// max_step writes, output backpressure, watchdog and verdict.
// Depends on bcs_pkg, battery_charge_smoother and bcs_checker.
module tb_battery_charge_smoother;
  import bcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN         = WINDOW_DEF;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_WORDS = 100;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned LONG_HOLD   = 150;

  logic                clk               = 1'b0;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_stall;
  logic [CHARGE_W-1:0] in_charge_percent = '0;
  logic                out_valid;
  logic                out_stall         = 1'b0;
  logic [CHARGE_W-1:0] out_shown_charge;
  logic                out_fluctuating;
  logic                cfg_wr_en         = 1'b0;
  logic [CHARGE_W-1:0] cfg_wr_data       = '0;

  int unsigned mismatches;
  int unsigned displays_owed;
  int unsigned smoothed_shown;
  int unsigned readings_sent = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles  = 0;
  logic [CHARGE_W-1:0] cur_step = MAX_STEP_RST;
  bit no_gaps = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  battery_charge_smoother #(.WINDOW(WIN)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_charge_percent (in_charge_percent),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_shown_charge  (out_shown_charge),
    .out_fluctuating   (out_fluctuating),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  bcs_checker #(.WIN(WIN)) checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_charge_percent (in_charge_percent),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_shown_charge  (out_shown_charge),
    .out_fluctuating   (out_fluctuating),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mismatches        (mismatches),
    .displays_owed     (displays_owed),
    .smoothed_shown    (smoothed_shown)
  );

  // Called just after a rising edge; returns on the edge that takes the word.
  task automatic send_reading(input logic [CHARGE_W-1:0] pct, input int unsigned gap);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_charge_percent <= pct;
    do @(posedge clk); while (in_stall);
    readings_sent++;
  endtask

  // Writes max_step once every expected output word has been taken.
  task automatic program_step(input logic [CHARGE_W-1:0] limit);
    in_valid <= 1'b0;
    @(posedge clk);
    while (displays_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_step = limit;
    settings_used++;
  endtask

  function automatic int unsigned pace();
    return no_gaps ? 0 : $urandom_range(0, 8);
  endfunction

  // A reading at full charge is sometimes sent as an out-of-range value.
  function automatic logic [CHARGE_W-1:0] overshoot(input int level);
    if (level >= 100 && $urandom_range(0, 1) == 1) return CHARGE_W'($urandom_range(101, 127));
    return CHARGE_W'(level);
  endfunction

  initial begin : stimulus
    logic [CHARGE_W-1:0] opening[22];
    logic [CHARGE_W-1:0] limit;
    int unsigned         sent_in_phase;
    int unsigned         span;
    int unsigned         pick;
    int unsigned         phase;
    int                  level;
    opening = '{7'd0, 7'd127, 7'd101, 7'd100, 7'd64, 7'd1, 7'd2, 7'd3,
                7'd50, 7'd52, 7'd50, 7'd52, 7'd50, 7'd52, 7'd50, 7'd52,
                7'd99, 7'd127, 7'd99, 7'd101, 7'd99, 7'd100};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Window fill with extreme and clamped readings, then steady zigzags that
    // must be smoothed, first at the reset step size.
    foreach (opening[i]) send_reading(opening[i], $urandom_range(0, 8));
    // With a zero step every neighbour counts as a jump.
    program_step('0);
    repeat (3) send_reading(7'd40, $urandom_range(0, 8));

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       limit = 7'd1;
        1:       limit = 7'd127;
        2:       limit = 7'd100;
        3:       limit = 7'd0;
        4:       limit = MAX_STEP_RST;
        default: limit = CHARGE_W'($urandom_range(2, 12));
      endcase
      program_step(limit);
      no_gaps = (phase % 3 == 2);
      sent_in_phase = 0;
      level = $urandom_range(0, 100);
      while (sent_in_phase < PHASE_WORDS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // Small steps below any nonzero limit let the walk reach the end.
          span = (cur_step > 1) ? ((cur_step - 1 > 10) ? 10 : cur_step - 1) : 0;
          repeat ($urandom_range(8, 20)) begin
            level = level + int'($urandom_range(0, 2 * span)) - int'(span);
            if (level < 0) level = 0;
            if (level > 100) level = 100;
            send_reading(overshoot(level), pace());
            sent_in_phase++;
          end
        end else if (pick < 9) begin
          level = $urandom_range(0, 120);
          if (level > 100) level = 100;
          send_reading(overshoot(level), pace());
          sent_in_phase++;
        end else begin
          repeat (4) begin
            send_reading(CHARGE_W'($urandom_range(0, 127)), pace());
            sent_in_phase++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (displays_owed != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Summary: %0d readings sent over %0d max_step settings,",
             readings_sent, settings_used);
    $display("         %0d output words carried a smoothed average.", smoothed_shown);
    if (mismatches == 0 && displays_owed == 0) begin
      $display("battery_charge_smoother regression: pass");
    end else begin
      $display("battery_charge_smoother regression: fail");
    end
    $finish;
  end

  // Output side: a random stall after every taken word, some stretches with
  // none, and two long holds that let the block back up into its input.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned taken;
    hold_left = 0;
    taken     = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        taken++;
        if (taken == 250 || taken == 640) hold_left = LONG_HOLD;
        else if ((taken / 100) % 3 == 1) hold_left = 0;
        else hold_left = $urandom_range(0, 8);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d output words still owed.",
               QUIET_LIMIT, displays_owed);
      $display("battery_charge_smoother regression: fail");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bcs_pkg.sv
src/bcs_ram.sv
src/bcs_div.sv
src/battery_charge_smoother.sv
tb/bcs_checker.sv
tb/tb_battery_charge_smoother.sv
